// ===== sv/variable_length_record_fifo_top_assert.svh =====
// Assertion macros used by the record FIFO datapath.
`ifndef VARIABLE_LENGTH_RECORD_FIFO_TOP_ASSERT_SVH
`define VARIABLE_LENGTH_RECORD_FIFO_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VLRF_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("record fifo invariant violated");
`define VLRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record fifo implication violated");
`else
`define VLRF_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define VLRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/vlrf_pkg.sv =====
// Types and constants shared by the record FIFO modules.
package vlrf_pkg;

    localparam int STORE_BYTES  = 1024;
    localparam int HEADER_BYTES = 4;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int FREE_W       = ADDR_W + 1;
    localparam int SIZE_W       = 10;
    localparam int DATA_W       = 8;
    localparam int HDR_CNT_W    = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int HDR_BITS     = 8 * HEADER_BYTES;

    typedef enum logic [1:0] {
        ACT_PUSH_BEGIN = 2'd0,
        ACT_PUSH_BYTE  = 2'd1,
        ACT_POP_BEGIN  = 2'd2,
        ACT_POP_BYTE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SEQ   = 2'd3
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [SIZE_W-1:0]   size;
        logic [DATA_W-1:0]   data_in;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [SIZE_W-1:0]   record_length;
        logic [DATA_W-1:0]   data_out;
        logic                byte_valid;
        logic                last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  push_accept;
        logic                  hdr_write;
        logic                  byte_write;
        logic                  pop_accept;
        logic                  hdr_read;
        logic                  hdr_last;
        logic                  byte_read;
        logic [HDR_CNT_W-1:0]  hdr_idx;
        logic                  res_valid;
        t_status               res_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic push_open;
        logic pop_open;
        logic empty;
        logic fits;
    } t_dp_stat;

endpackage

// ===== sv/vlrf_ctrl.sv =====
// Controller state machine that sequences transactions and header transfers.
module vlrf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  vlrf_pkg::t_action    i_action,
    input  vlrf_pkg::t_dp_stat   i_stat,
    output logic                 o_busy,
    output vlrf_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE     = 3'b001,
        S_PUSH_HDR = 3'b010,
        S_POP_HDR  = 3'b100
    } t_state;

    t_state                           r_state, n_state;
    logic [vlrf_pkg::HDR_CNT_W-1:0]   r_cnt, n_cnt;
    logic                             cnt_last;

    assign cnt_last = (r_cnt == vlrf_pkg::HDR_CNT_W'(vlrf_pkg::HEADER_BYTES - 1));
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.res_status = vlrf_pkg::ST_OK;
        o_cmd.hdr_idx    = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    o_cmd.res_valid = 1'b1;
                    unique case (i_action)
                        vlrf_pkg::ACT_PUSH_BEGIN: begin
                            if (i_stat.push_open || i_stat.pop_open) begin
                                o_cmd.res_status = vlrf_pkg::ST_SEQ;
                            end else if (!i_stat.fits) begin
                                o_cmd.res_status = vlrf_pkg::ST_FULL;
                            end else begin
                                o_cmd.res_valid   = 1'b0;
                                o_cmd.push_accept = 1'b1;
                                n_state           = S_PUSH_HDR;
                            end
                        end
                        vlrf_pkg::ACT_PUSH_BYTE: begin
                            if (!i_stat.push_open) begin
                                o_cmd.res_status = vlrf_pkg::ST_SEQ;
                            end else begin
                                o_cmd.byte_write = 1'b1;
                            end
                        end
                        vlrf_pkg::ACT_POP_BEGIN: begin
                            if (i_stat.push_open || i_stat.pop_open) begin
                                o_cmd.res_status = vlrf_pkg::ST_SEQ;
                            end else if (i_stat.empty) begin
                                o_cmd.res_status = vlrf_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.res_valid  = 1'b0;
                                o_cmd.pop_accept = 1'b1;
                                n_state          = S_POP_HDR;
                            end
                        end
                        vlrf_pkg::ACT_POP_BYTE: begin
                            if (!i_stat.pop_open) begin
                                o_cmd.res_status = vlrf_pkg::ST_SEQ;
                            end else begin
                                o_cmd.byte_read = 1'b1;
                            end
                        end
                        default: o_cmd.res_status = vlrf_pkg::ST_SEQ;
                    endcase
                end
            end
            S_PUSH_HDR: begin
                o_cmd.hdr_write = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (cnt_last) begin
                    o_cmd.res_valid = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_POP_HDR: begin
                o_cmd.hdr_read = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    o_cmd.hdr_last  = 1'b1;
                    o_cmd.res_valid = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/vlrf_datapath.sv =====
// Datapath with the byte store, ring pointers, space accounting and result register.
`include "variable_length_record_fifo_top_assert.svh"
module vlrf_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vlrf_pkg::t_in_item   i_item,
    input  vlrf_pkg::t_cmd       i_cmd,
    output vlrf_pkg::t_dp_stat   o_stat,
    output logic                 o_valid,
    output vlrf_pkg::t_out_item  o_result
);

    localparam int ADDR_W = vlrf_pkg::ADDR_W;
    localparam int FREE_W = vlrf_pkg::FREE_W;
    localparam int SIZE_W = vlrf_pkg::SIZE_W;
    localparam int DATA_W = vlrf_pkg::DATA_W;

    logic [DATA_W-1:0] mem [vlrf_pkg::STORE_BYTES];
    logic [DATA_W-1:0] r_rdata;

    logic [ADDR_W-1:0] r_write_pos, n_write_pos;
    logic [ADDR_W-1:0] r_read_pos, n_read_pos;
    logic [FREE_W-1:0] r_free, n_free;
    logic [SIZE_W-1:0] r_push_left, n_push_left;
    logic [SIZE_W-1:0] r_deliver_left, n_deliver_left;
    logic [SIZE_W-1:0] r_rec_len, n_rec_len;
    logic [ADDR_W-1:0] r_rec_end, n_rec_end;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_len_acc, n_len_acc;

    logic                  r_res_valid;
    vlrf_pkg::t_status     r_res_status;
    logic [SIZE_W-1:0]     r_res_len, n_res_len;
    logic                  r_res_bv, r_res_last, n_res_last;

    logic                  we;
    logic [DATA_W-1:0]     wdata;
    logic [SIZE_W-1:0]     len_now;
    logic [SIZE_W-1:0]     deliver_now;
    logic [SIZE_W-1:0]     release_len;
    logic [FREE_W:0]       release_sum;
    logic [FREE_W-1:0]     free_released;
    logic [FREE_W:0]       need;
    logic                  size_too_wide;
    logic [4:0]            hdr_shift;

    assign hdr_shift = {i_cmd.hdr_idx, 3'b000};
    assign len_now   = r_len_acc | (SIZE_W'(r_rdata) << hdr_shift);
    assign deliver_now = (len_now < r_size) ? len_now : r_size;

    // Length fields wider than the header can carry are refused as full.
    assign size_too_wide = (vlrf_pkg::HDR_BITS < SIZE_W) &&
                           ((i_item.size >> vlrf_pkg::HDR_BITS) != '0);
    assign need = (FREE_W + 1)'(i_item.size) + (FREE_W + 1)'(vlrf_pkg::HEADER_BYTES);

    assign o_stat.push_open = (r_push_left != '0);
    assign o_stat.pop_open  = (r_deliver_left != '0);
    assign o_stat.empty     = (r_free >= FREE_W'(vlrf_pkg::STORE_BYTES));
    assign o_stat.fits      = (need <= (FREE_W + 1)'(r_free)) && !size_too_wide;

    // Record space comes back when its last delivered byte leaves.
    assign release_len   = i_cmd.hdr_last ? len_now : r_rec_len;
    assign release_sum   = (FREE_W + 1)'(r_free) + (FREE_W + 1)'(release_len)
                         + (FREE_W + 1)'(vlrf_pkg::HEADER_BYTES);
    assign free_released = (release_sum > (FREE_W + 1)'(vlrf_pkg::STORE_BYTES))
                         ? FREE_W'(vlrf_pkg::STORE_BYTES) : release_sum[FREE_W-1:0];

    assign we    = i_cmd.hdr_write || i_cmd.byte_write;
    assign wdata = i_cmd.hdr_write ? DATA_W'(r_size >> hdr_shift) : i_item.data_in;

    always_comb begin
        n_write_pos    = r_write_pos;
        n_read_pos     = r_read_pos;
        n_free         = r_free;
        n_push_left    = r_push_left;
        n_deliver_left = r_deliver_left;
        n_rec_len      = r_rec_len;
        n_rec_end      = r_rec_end;
        n_size         = r_size;
        n_len_acc      = r_len_acc;
        n_res_len      = '0;
        n_res_last     = 1'b0;
        if (i_cmd.push_accept) begin
            n_size      = i_item.size;
            n_free      = r_free - need[FREE_W-1:0];
            n_push_left = i_item.size;
        end
        if (we) begin
            n_write_pos = r_write_pos + 1'b1;
        end
        if (i_cmd.byte_write) begin
            n_push_left = r_push_left - 1'b1;
        end
        if (i_cmd.pop_accept) begin
            n_size     = i_item.size;
            n_len_acc  = '0;
            n_read_pos = r_read_pos + 1'b1;
        end
        if (i_cmd.hdr_read) begin
            n_len_acc  = len_now;
            n_read_pos = r_read_pos + 1'b1;
        end
        // The read position already points at the first payload byte here.
        if (i_cmd.hdr_last) begin
            n_rec_len      = len_now;
            n_rec_end      = r_read_pos + ADDR_W'(len_now);
            n_deliver_left = deliver_now;
            n_res_len      = len_now;
            n_read_pos     = r_read_pos;
            if (deliver_now == '0) begin
                n_free     = free_released;
                n_read_pos = r_read_pos + ADDR_W'(len_now);
            end
        end
        if (i_cmd.byte_read) begin
            n_deliver_left = r_deliver_left - 1'b1;
            n_read_pos     = r_read_pos + 1'b1;
            if (r_deliver_left == SIZE_W'(1)) begin
                n_res_last = 1'b1;
                n_free     = free_released;
                n_read_pos = r_rec_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_write_pos] <= wdata;
        end
        r_rdata <= mem[r_read_pos];
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_len_acc    <= n_len_acc;
        r_rec_end    <= n_rec_end;
        r_res_status <= i_cmd.res_status;
        r_res_len    <= n_res_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos    <= '0;
            r_read_pos     <= '0;
            r_free         <= FREE_W'(vlrf_pkg::STORE_BYTES);
            r_push_left    <= '0;
            r_deliver_left <= '0;
            r_rec_len      <= '0;
            r_res_valid    <= 1'b0;
            r_res_bv       <= 1'b0;
            r_res_last     <= 1'b0;
        end else begin
            r_write_pos    <= n_write_pos;
            r_read_pos     <= n_read_pos;
            r_free         <= n_free;
            r_push_left    <= n_push_left;
            r_deliver_left <= n_deliver_left;
            r_rec_len      <= n_rec_len;
            r_res_valid    <= i_cmd.res_valid;
            r_res_bv       <= i_cmd.byte_read;
            r_res_last     <= n_res_last;
        end
    end

    assign o_valid                = r_res_valid;
    assign o_result.status        = r_res_status;
    assign o_result.record_length = r_res_len;
    assign o_result.data_out      = r_res_bv ? r_rdata : '0;
    assign o_result.byte_valid    = r_res_bv;
    assign o_result.last          = r_res_last;

    `VLRF_ASSERT_ALWAYS(a_open_exclusive, i_clk, i_rst_n, !(o_stat.push_open && o_stat.pop_open))
    `VLRF_ASSERT_ALWAYS(a_free_range, i_clk, i_rst_n, r_free <= FREE_W'(vlrf_pkg::STORE_BYTES))
    `VLRF_ASSERT_IMPL(a_last_has_byte, i_clk, i_rst_n, r_res_last, r_res_bv && r_res_valid)
    `VLRF_ASSERT_IMPL(a_byte_ok, i_clk, i_rst_n, r_res_bv, r_res_valid && r_res_status == vlrf_pkg::ST_OK)

endmodule

// ===== sv/variable_length_record_fifo_top.sv =====
// Top level of the variable-length record FIFO.
// This block keeps variable-length records in a 1024-byte ring store, each record
// being a 4-byte little-endian length header followed by its payload, both of which
// wrap at the end of the store. A transaction is accepted at a rising clock edge
// where start is high and busy is low, and every accepted transaction produces
// exactly one result, shown on o_result for a single cycle with o_valid high.
// The receiver cannot stall, so it must capture each result in the cycle it is
// shown. Push payload bytes, pop payload bytes and every refused transaction keep
// busy low, so these can be issued back to back. A push begin or a pop begin that
// is accepted holds busy high while the controller moves the header one byte per
// cycle through the single write port or the single registered read port of the
// store, and its result appears in the cycle busy falls. A pop begin returns the
// stored length; the following pop byte transactions deliver up to the smaller of
// that length and the capacity given, and the rest of the record is skipped. The
// space of a record is freed when its last delivered byte leaves, or at the pop
// begin itself when nothing is to be delivered. The store is not cleared by reset;
// no clearing pass is needed since only bytes already written can be read.
module variable_length_record_fifo_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  vlrf_pkg::t_in_item   i_item,
    output logic                 o_valid,
    output vlrf_pkg::t_out_item  o_result
);

    // Command and status groups between controller and datapath.
    vlrf_pkg::t_cmd      cmd;
    vlrf_pkg::t_dp_stat  stat;

    // The controller decodes each transaction against the datapath status.
    vlrf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // The datapath owns the store, the pointers and the result register.
    vlrf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
